>>> src/sws_pkg.sv
// Shared types, codes and helpers for the stop-and-wait sender.
// No dependencies; imported by every module of the block.
package sws_pkg;

	localparam int DATA_BYTES = 10;
	localparam logic [3:0] MAX_LEN = 4'(DATA_BYTES);
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;

	typedef enum logic [1:0] {
		REQ_SEND = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_TICK = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_DELIVERED = 3'd1,
		EV_TIMEOUT   = 3'd2,
		EV_BAD_CKSUM = 3'd3,
		EV_BAD_SEQ   = 3'd4,
		EV_IGNORED   = 3'd5
	} event_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WAIT = 1'b1
	} sws_state_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [63:0]        data_lo;
		logic [15:0]        data_hi;
		logic [3:0]         byte_count;
		logic signed [31:0] ack_number;
		logic signed [31:0] ack_check;
	} in_item_t;

	typedef struct packed {
		logic              tx_valid;
		logic              tx_seq;
		logic [3:0]        tx_len;
		logic signed [7:0] tx_cksum;
		logic [63:0]       tx_data_lo;
		logic [15:0]       tx_data_hi;
		logic [2:0]        event_code;
		logic              busy_res;
	} out_item_t;

	// strobes from the pipeline wrapper into the control stage
	typedef struct packed {
		logic fire;
		logic cfg_we;
	} ctl_t;

	function automatic logic [3:0] clamp_len(logic [3:0] n);
		return (n > MAX_LEN) ? MAX_LEN : n;
	endfunction

	// byte-enable mask over data bytes 0..9, bytes at or past len cleared
	function automatic logic [79:0] data_mask(logic [3:0] len);
		logic [79:0] m;
		m = '0;
		for (int i = 0; i < DATA_BYTES; i++) begin
			if (4'(i) < len) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

>>> src/sws_cksum.sv
// 8-bit XOR checksum over the 32-bit number, the length and the (pre-masked) data bytes.
// Uses sws_pkg; pure combinational XOR tree.
module sws_cksum (
	input  logic [31:0] number,
	input  logic [3:0]  len,
	input  logic [63:0] lo,
	input  logic [15:0] hi,
	output logic [7:0]  sum
);
	import sws_pkg::*;

	always_comb begin
		logic [7:0] acc;
		acc = number[7:0] ^ number[15:8] ^ number[23:16] ^ number[31:24];
		acc = acc ^ {4'b0, len};
		for (int i = 0; i < 8; i++) begin
			acc = acc ^ lo[i*8 +: 8];
		end
		acc = acc ^ hi[7:0] ^ hi[15:8];
		sum = acc;
	end

endmodule

>>> src/sws_ctrl.sv
// Sender state (wait flag, sequence bit, timer, held packet) and result logic.
// Uses sws_pkg and sws_cksum; evaluates one item per fire strobe.
module sws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  sws_pkg::ctl_t      ctl,
	input  sws_pkg::in_item_t  item,
	input  logic [15:0]        cfg_data,
	output sws_pkg::out_item_t res
);
	import sws_pkg::*;

	sws_state_t  state_q, state_nxt;
	logic        seq_q;
	logic [15:0] timer_q;
	logic [15:0] timeout_q;
	logic [3:0]  held_len_q;
	logic [7:0]  held_check_q;
	logic [63:0] held_lo_q;
	logic [15:0] held_hi_q;

	logic [3:0]  len;
	logic [79:0] mask;
	logic [63:0] m_lo;
	logic [15:0] m_hi;
	logic [31:0] number;
	logic [7:0]  ck;
	logic [31:0] expect_ck;
	logic [16:0] timer_inc;
	logic        tmo;

	logic        do_load, do_retx, do_good, do_tick;
	event_t      ev;

	assign len  = clamp_len(item.byte_count);
	assign mask = data_mask(len);
	assign m_lo = item.data_lo & mask[63:0];
	assign m_hi = item.data_hi & mask[79:64];

	// one checksum unit serves both the outgoing packet and the ACK check
	assign number = (item.req_type == REQ_ACK) ? item.ack_number : {31'b0, seq_q};

	sws_cksum u_cksum (
		.number (number),
		.len    (len),
		.lo     (m_lo),
		.hi     (m_hi),
		.sum    (ck)
	);

	assign expect_ck = {{24{ck[7]}}, ck};
	assign timer_inc = {1'b0, timer_q} + 17'd1;
	assign tmo       = timer_inc >= {1'b0, timeout_q};

	// decision / output decode
	always_comb begin
		do_load = 1'b0;
		do_retx = 1'b0;
		do_good = 1'b0;
		do_tick = 1'b0;
		ev      = EV_NONE;
		case (item.req_type)
			REQ_SEND: begin
				if (state_q == ST_WAIT) begin
					ev = EV_IGNORED;
				end else begin
					do_load = 1'b1;
				end
			end
			REQ_ACK: begin
				if (state_q == ST_IDLE) begin
					ev = EV_IGNORED;
				end else if (item.ack_check != expect_ck) begin
					ev      = EV_BAD_CKSUM;
					do_retx = 1'b1;
				end else if (item.ack_number != {31'b0, seq_q}) begin
					ev      = EV_BAD_SEQ;
					do_retx = 1'b1;
				end else begin
					ev      = EV_DELIVERED;
					do_good = 1'b1;
				end
			end
			REQ_TICK: begin
				if (state_q == ST_WAIT) begin
					if (tmo) begin
						ev      = EV_TIMEOUT;
						do_retx = 1'b1;
					end else begin
						do_tick = 1'b1;
					end
				end
			end
			default: ev = EV_IGNORED;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (ctl.fire && do_load) state_nxt = ST_WAIT;
			ST_WAIT: if (ctl.fire && do_good) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// result item
	always_comb begin
		res            = '0;
		res.event_code = ev;
		res.busy_res   = (state_nxt == ST_WAIT);
		if (do_load) begin
			res.tx_valid   = 1'b1;
			res.tx_seq     = seq_q;
			res.tx_len     = len;
			res.tx_cksum   = ck;
			res.tx_data_lo = m_lo;
			res.tx_data_hi = m_hi;
		end else if (do_retx) begin
			res.tx_valid   = 1'b1;
			res.tx_seq     = seq_q;
			res.tx_len     = held_len_q;
			res.tx_cksum   = held_check_q;
			res.tx_data_lo = held_lo_q;
			res.tx_data_hi = held_hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seq_q        <= 1'b0;
			timer_q      <= '0;
			timeout_q    <= TIMEOUT_RST;
			held_len_q   <= '0;
			held_check_q <= '0;
		end else begin
			if (ctl.cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (ctl.fire) begin
				state_q <= state_nxt;
				if (do_load || do_retx || do_good) begin
					timer_q <= '0;
				end else if (do_tick) begin
					timer_q <= timer_inc[15:0];
				end
				if (do_good) begin
					seq_q <= ~seq_q;
				end
				if (do_load) begin
					held_len_q   <= len;
					held_check_q <= ck;
				end
			end
		end
	end

	// held payload, undefined until the first send
	always_ff @(posedge clk) begin
		if (ctl.fire && do_load) begin
			held_lo_q <= m_lo;
			held_hi_q <= m_hi;
		end
	end

endmodule

>>> src/stop_and_wait_sender.sv
// Top level of the alternating-bit sender: input register, control stage, result register.
// Uses sws_pkg and sws_ctrl (which holds sws_cksum).
//
//  channel | signals                        | moves
//  --------+--------------------------------+----------------------------------
//  in      | in_valid  in_ready  in_data    | one request (send / ACK / tick)
//  out     | out_valid out_ready out_data   | one result per request
//  cfg     | cfg_valid cfg_ready cfg_data   | timeout_ticks write
//
// One request per cycle sustained while out_ready stays high; a request passes the input
// register, then the result register, before out_valid rises.
// The control stage (checksum tree, compare, state update) is the only logic
// between the two registers; sequence bit and timer change only on a fire.
// A stalled out channel holds the result register and the input register,
// then in_ready drops; cfg_ready is always high.
// Reset: idle, sequence bit 0, timer 0, timeout_ticks 1000, both stages empty.
module stop_and_wait_sender (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sws_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sws_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import sws_pkg::*;

	in_item_t  in_s1;
	logic      in_vld_s1;
	out_item_t out_s2;
	logic      out_vld_s2;
	out_item_t res;
	ctl_t      ctl;
	logic      fire;

	// stage 1 advances when the result register is empty or being drained
	assign fire       = in_vld_s1 && (!out_vld_s2 || out_ready);
	assign in_ready   = !in_vld_s1 || fire;
	assign cfg_ready  = 1'b1;
	assign ctl.fire   = fire;
	assign ctl.cfg_we = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1  <= 1'b0;
			out_vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				in_vld_s1 <= in_valid;
			end
			if (fire) begin
				out_vld_s2 <= 1'b1;
			end else if (out_ready) begin
				out_vld_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		if (fire) begin
			out_s2 <= res;
		end
	end

	sws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.item     (in_s1),
		.cfg_data (cfg_data),
		.res      (res)
	);

	assign out_valid = out_vld_s2;
	assign out_data  = out_s2;

`ifndef ASSERT_OFF
	// no packet: every packet field reads zero
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tx_valid |-> !out_data.tx_seq && out_data.tx_len == 4'd0
			&& out_data.tx_cksum == 8'sd0 && out_data.tx_data_lo == 64'd0
			&& out_data.tx_data_hi == 16'd0)
		else $error("transfer without packet carries nonzero packet fields");

	// a delivered ACK frees the sender and sends nothing
	a_delivered_frees: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_code == EV_DELIVERED |->
			!out_data.busy_res && !out_data.tx_valid)
		else $error("delivered event left sender busy or sent a packet");

	// a held request that cannot advance keeps stage 1 occupied
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_vld_s1 && !fire |=> in_vld_s1 && $stable(in_s1))
		else $error("stalled request lost from input register");

	// empty input register always accepts
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_vld_s1 |-> in_ready)
		else $error("in_ready low with empty input register");
`endif

endmodule
